// ===== sv/pjac_pkg.sv =====
// Shared widths, column indices and pipeline bundle types for the pinhole
// projection Jacobian block. No dependencies; used by pjac_div and the top level.
package pjac_pkg;

  localparam int QW         = 48;  // result magnitude bits, Q32.16
  localparam int NW         = 95;  // dividend width: 31-bit f times 64-bit term
  localparam int DW         = 76;  // divisor width: z*z shifted left by 14
  localparam int COLS       = 9;   // derivative columns per row
  localparam int PRE_STAGES = 8;   // register stages ahead of the dividers
  localparam int DIV_LAT    = QW + 2;
  localparam int TAG_N      = PRE_STAGES + DIV_LAT;

  localparam logic [30:0] FOCAL_RST = 31'd32768000;

  localparam int C_DPT_X   = 0;
  localparam int C_DPT_Y   = 1;
  localparam int C_DPT_Z   = 2;
  localparam int C_DROT_X  = 3;
  localparam int C_DROT_Y  = 4;
  localparam int C_DROT_Z  = 5;
  localparam int C_DMOVE_X = 6;
  localparam int C_DMOVE_Y = 7;
  localparam int C_DMOVE_Z = 8;

  typedef struct packed {
    logic valid;
    logic row;
    logic bad;
  } pjac_tag_t;

  typedef struct packed {
    logic [NW-1:0] n;
    logic [DW-1:0] d;
    logic          neg;
  } pjac_div_in_t;

endpackage

// ===== sv/pjac_div.sv =====
// One column of the pipelined restoring divider: trunc(n/d), saturated and signed.
// One quotient bit per stage; depends on pjac_pkg.
module pjac_div
  import pjac_pkg::*;
(
  input  logic            clk,
  input  logic            en,
  input  pjac_div_in_t    op,
  output logic [QW-1:0]   res
);

  logic [NW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW+1];
  logic          neg_r [QW+1];
  logic          ovf_r [QW+1];
  logic [QW-1:0] res_r;
  logic [QW-1:0] lim;
  logic [QW-1:0] mag;

  // quotient of QW bits or more saturates anyway
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= op.n;
      den_r[0] <= op.d;
      quo_r[0] <= '0;
      neg_r[0] <= op.neg;
      ovf_r[0] <= (op.n >> QW) >= NW'(op.d);
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int B = QW - 1 - k;
    logic take;

    assign take = (rem_r[k] >> B) >= NW'(den_r[k]);

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[k+1] <= quo_r[k] | (QW'(take) << B);
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
      end
    end

    if (k < QW - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1] <= take ? rem_r[k] - (NW'(den_r[k]) << B) : rem_r[k];
          den_r[k+1] <= den_r[k];
        end
      end
    end
  end

  assign lim = neg_r[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
  assign mag = (ovf_r[QW] || quo_r[QW] > lim) ? lim : quo_r[QW];

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= neg_r[QW] ? QW'(0) - mag : mag;
    end
  end

  assign res = res_r;

endmodule

// ===== sv/pinhole_projection_jacobian_top.sv =====
// Pinhole projection Jacobian top level: pose transform, numerator build and
// nine divider columns. Depends on pjac_pkg and pjac_div.
//
// Each accepted transaction (world point plus quaternion/translation pose) yields
// two result rows, u first then v, on consecutive cycles when the output is not
// stalled. The block accepts a new transaction while the last one issues its v row
// and emits one row per cycle unless the output stalls; both rows of a transaction
// share the nine divider columns, each a 48-stage restoring divider retiring one
// quotient bit per stage. From input acceptance to the u row on the output, a
// transaction passes an input hold stage, eight stages of multiply/add (quaternion
// products, rotation matrix, rotate, camera point, squares and cross terms,
// numerators, focal products, final sums) and 50 divider stages including load
// and saturation. A stall on the output freezes the whole pipeline. The focal
// length register must only be written while the pipeline is empty.
module pinhole_projection_jacobian_top
  import pjac_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [30:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  input  logic signed [31:0] in_quat_w,
  input  logic signed [31:0] in_quat_x,
  input  logic signed [31:0] in_quat_y,
  input  logic signed [31:0] in_quat_z,
  input  logic signed [31:0] in_shift_x,
  input  logic signed [31:0] in_shift_y,
  input  logic signed [31:0] in_shift_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_row_is_v,
  output logic               out_last_row,
  output logic               out_depth_bad,
  output logic signed [47:0] out_dpt_x,
  output logic signed [47:0] out_dpt_y,
  output logic signed [47:0] out_dpt_z,
  output logic signed [47:0] out_drot_x,
  output logic signed [47:0] out_drot_y,
  output logic signed [47:0] out_drot_z,
  output logic signed [47:0] out_dmove_x,
  output logic signed [47:0] out_dmove_y,
  output logic signed [47:0] out_dmove_z
);

  localparam int QI_W = 0;
  localparam int QI_X = 1;
  localparam int QI_Y = 2;
  localparam int QI_Z = 3;

  localparam int T_XX = 0;
  localparam int T_YY = 1;
  localparam int T_ZZ = 2;
  localparam int T_XY = 3;
  localparam int T_XZ = 4;
  localparam int T_YZ = 5;
  localparam int T_WX = 6;
  localparam int T_WY = 7;
  localparam int T_WZ = 8;

  localparam logic signed [36:0] ONE_Q30 = 37'sd1073741824;

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -37'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  logic        adv;
  logic [30:0] focal_r;

  // input hold: one transaction issues the u row then the v row
  logic               hold_v_r;
  logic               hold_row_r;
  logic signed [31:0] hpt_r [3];
  logic signed [31:0] hq_r  [4];
  logic signed [31:0] hsh_r [3];

  pjac_tag_t tag_r [TAG_N];

  // stage 1
  logic signed [63:0] qp [9];
  logic signed [34:0] tt_r [9];
  logic signed [31:0] s1_pt_r [3];
  logic signed [31:0] s1_sh_r [3];
  // stage 2
  logic signed [36:0] rs [3][3];
  logic signed [31:0] rm_r [3][3];
  logic signed [31:0] s2_pt_r [3];
  logic signed [31:0] s2_sh_r [3];
  // stage 3
  logic signed [63:0] rxp [3][3];
  logic signed [33:0] rx_r [3][3];
  logic signed [31:0] s3_sh_r [3];
  logic signed [31:0] s3_rs_r [3];
  logic signed [31:0] s3_r2_r [3];
  // stage 4
  logic signed [36:0] psum [3];
  logic signed [31:0] p_nxt [3];
  logic               bad_nxt;
  logic signed [31:0] p_r [3];
  logic signed [31:0] s4_rs_r [3];
  logic signed [31:0] s4_r2_r [3];
  // stage 5
  logic [30:0]        z_u;
  logic [31:0]        ax_m;
  logic [31:0]        ay_m;
  logic [31:0]        sq_in;
  logic signed [31:0] c_m;
  logic [61:0]        zz_m;
  logic [63:0]        sq_m;
  logic [63:0]        axy_m;
  logic signed [63:0] rz_m [3];
  logic signed [63:0] cr_m [3];
  logic [61:0]        zz_r;
  logic [63:0]        sq_r;
  logic [63:0]        axy_r;
  logic signed [63:0] rz_r [3];
  logic signed [63:0] cr_r [3];
  logic [31:0]        ax_r;
  logic [31:0]        ay_r;
  logic               nx_r;
  logic               ny_r;
  logic [30:0]        z_r;
  // stage 6
  logic signed [64:0] df [3];
  logic signed [64:0] dneg [3];
  logic [63:0]        ssum;
  logic [DW-1:0]      den_zz;
  logic [DW-1:0]      den_z;
  logic [63:0]        a_nxt   [COLS];
  logic               neg_nxt [COLS];
  logic [DW-1:0]      den_nxt [COLS];
  logic [63:0]        a_r      [COLS];
  logic               s6_neg_r [COLS];
  logic [DW-1:0]      s6_den_r [COLS];
  // stage 7
  logic [62:0]        ph_m [COLS];
  logic [62:0]        pl_m [COLS];
  logic [62:0]        ph_r [COLS];
  logic [62:0]        pl_r [COLS];
  logic               s7_neg_r [COLS];
  logic [DW-1:0]      s7_den_r [COLS];
  // stage 8
  pjac_div_in_t       dop_r [COLS];
  logic [QW-1:0]      res_w [COLS];

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && (!hold_v_r || hold_row_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_r <= FOCAL_RST;
    end else if (cfg_wr_en) begin
      focal_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r   <= 1'b0;
      hold_row_r <= 1'b0;
    end else if (adv) begin
      if (in_valid && in_ready) begin
        hold_v_r   <= 1'b1;
        hold_row_r <= 1'b0;
      end else if (hold_v_r && !hold_row_r) begin
        hold_row_r <= 1'b1;
      end else begin
        hold_v_r   <= 1'b0;
        hold_row_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hpt_r[0]    <= in_point_x;
      hpt_r[1]    <= in_point_y;
      hpt_r[2]    <= in_point_z;
      hq_r[QI_W]  <= in_quat_w;
      hq_r[QI_X]  <= in_quat_x;
      hq_r[QI_Y]  <= in_quat_y;
      hq_r[QI_Z]  <= in_quat_z;
      hsh_r[0]    <= in_shift_x;
      hsh_r[1]    <= in_shift_y;
      hsh_r[2]    <= in_shift_z;
    end
  end

  // tag_r[k] travels with stage k+1; depth flag joins at stage 4
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TAG_N; k++) begin
        tag_r[k] <= '0;
      end
    end else if (adv) begin
      tag_r[0] <= '{valid: hold_v_r, row: hold_row_r, bad: 1'b0};
      for (int k = 1; k < TAG_N; k++) begin
        if (k == 3) begin
          tag_r[k] <= '{valid: tag_r[2].valid, row: tag_r[2].row, bad: bad_nxt};
        end else begin
          tag_r[k] <= tag_r[k-1];
        end
      end
    end
  end

  // stage 1: quaternion products, floor(a*b / 2^29)
  assign qp[T_XX] = hq_r[QI_X] * hq_r[QI_X];
  assign qp[T_YY] = hq_r[QI_Y] * hq_r[QI_Y];
  assign qp[T_ZZ] = hq_r[QI_Z] * hq_r[QI_Z];
  assign qp[T_XY] = hq_r[QI_X] * hq_r[QI_Y];
  assign qp[T_XZ] = hq_r[QI_X] * hq_r[QI_Z];
  assign qp[T_YZ] = hq_r[QI_Y] * hq_r[QI_Z];
  assign qp[T_WX] = hq_r[QI_W] * hq_r[QI_X];
  assign qp[T_WY] = hq_r[QI_W] * hq_r[QI_Y];
  assign qp[T_WZ] = hq_r[QI_W] * hq_r[QI_Z];

  // stage 2: rotation matrix in Q2.30
  always_comb begin
    rs[0][0] = ONE_Q30 - 37'(tt_r[T_YY]) - 37'(tt_r[T_ZZ]);
    rs[0][1] = 37'(tt_r[T_XY]) - 37'(tt_r[T_WZ]);
    rs[0][2] = 37'(tt_r[T_XZ]) + 37'(tt_r[T_WY]);
    rs[1][0] = 37'(tt_r[T_XY]) + 37'(tt_r[T_WZ]);
    rs[1][1] = ONE_Q30 - 37'(tt_r[T_XX]) - 37'(tt_r[T_ZZ]);
    rs[1][2] = 37'(tt_r[T_YZ]) - 37'(tt_r[T_WX]);
    rs[2][0] = 37'(tt_r[T_XZ]) - 37'(tt_r[T_WY]);
    rs[2][1] = 37'(tt_r[T_YZ]) + 37'(tt_r[T_WX]);
    rs[2][2] = ONE_Q30 - 37'(tt_r[T_XX]) - 37'(tt_r[T_YY]);
  end

  // stage 3: R*X products
  for (genvar i = 0; i < 3; i++) begin : g_rx
    for (genvar j = 0; j < 3; j++) begin : g_col
      assign rxp[i][j] = rm_r[i][j] * s2_pt_r[j];
    end
  end

  // stage 4: camera point
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      psum[i] = 37'(s3_sh_r[i]) + 37'(rx_r[i][0]) + 37'(rx_r[i][1]) + 37'(rx_r[i][2]);
      p_nxt[i] = sat32(psum[i]);
    end
    bad_nxt = p_nxt[2][31] || (p_nxt[2] == '0);
  end

  // stage 5: squares and cross terms; z is positive whenever the row is used
  assign z_u   = p_r[2][30:0];
  assign ax_m  = p_r[0][31] ? 32'd0 - p_r[0] : p_r[0];
  assign ay_m  = p_r[1][31] ? 32'd0 - p_r[1] : p_r[1];
  assign sq_in = tag_r[3].row ? ay_m : ax_m;
  assign c_m   = tag_r[3].row ? p_r[1] : p_r[0];
  assign zz_m  = z_u * z_u;
  assign sq_m  = sq_in * sq_in;
  assign axy_m = ax_m * ay_m;
  for (genvar j = 0; j < 3; j++) begin : g_rz
    assign rz_m[j] = s4_rs_r[j] * p_r[2];
    assign cr_m[j] = c_m * s4_r2_r[j];
  end

  // stage 6: every term becomes f * a / den, den being z*z (shifted) or z
  assign ssum   = 64'(zz_r) + sq_r;
  assign den_zz = DW'(zz_r);
  assign den_z  = DW'(z_r);

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      df[j]   = 65'(rz_r[j]) - 65'(cr_r[j]);
      dneg[j] = -df[j];
      a_nxt[j]   = df[j][64] ? dneg[j][63:0] : df[j][63:0];
      neg_nxt[j] = !df[j][64] && (df[j] != '0);
      den_nxt[j] = den_zz << 14;
    end
    if (!tag_r[4].row) begin
      a_nxt[C_DROT_X]    = axy_r;
      neg_nxt[C_DROT_X]  = nx_r ^ ny_r;
      den_nxt[C_DROT_X]  = den_zz;
      a_nxt[C_DROT_Y]    = ssum;
      neg_nxt[C_DROT_Y]  = 1'b1;
      den_nxt[C_DROT_Y]  = den_zz;
      a_nxt[C_DROT_Z]    = 64'(ay_r);
      neg_nxt[C_DROT_Z]  = ny_r;
      den_nxt[C_DROT_Z]  = den_z;
      a_nxt[C_DMOVE_X]   = 64'd65536;
      neg_nxt[C_DMOVE_X] = 1'b1;
      den_nxt[C_DMOVE_X] = den_z;
      a_nxt[C_DMOVE_Y]   = '0;
      neg_nxt[C_DMOVE_Y] = 1'b0;
      den_nxt[C_DMOVE_Y] = den_z;
      a_nxt[C_DMOVE_Z]   = 64'(ax_r) << 16;
      neg_nxt[C_DMOVE_Z] = nx_r;
      den_nxt[C_DMOVE_Z] = den_zz;
    end else begin
      a_nxt[C_DROT_X]    = ssum;
      neg_nxt[C_DROT_X]  = 1'b0;
      den_nxt[C_DROT_X]  = den_zz;
      a_nxt[C_DROT_Y]    = axy_r;
      neg_nxt[C_DROT_Y]  = !(nx_r ^ ny_r);
      den_nxt[C_DROT_Y]  = den_zz;
      a_nxt[C_DROT_Z]    = 64'(ax_r);
      neg_nxt[C_DROT_Z]  = !nx_r;
      den_nxt[C_DROT_Z]  = den_z;
      a_nxt[C_DMOVE_X]   = '0;
      neg_nxt[C_DMOVE_X] = 1'b0;
      den_nxt[C_DMOVE_X] = den_z;
      a_nxt[C_DMOVE_Y]   = 64'd65536;
      neg_nxt[C_DMOVE_Y] = 1'b1;
      den_nxt[C_DMOVE_Y] = den_z;
      a_nxt[C_DMOVE_Z]   = 64'(ay_r) << 16;
      neg_nxt[C_DMOVE_Z] = ny_r;
      den_nxt[C_DMOVE_Z] = den_zz;
    end
    // bad depth: 0/1 gives a clean zero through the dividers
    if (tag_r[4].bad) begin
      for (int k = 0; k < COLS; k++) begin
        a_nxt[k]   = '0;
        den_nxt[k] = DW'(1);
      end
    end
  end

  // stage 7: focal length times the term, in two 32-bit halves
  for (genvar k = 0; k < COLS; k++) begin : g_col
    assign ph_m[k] = focal_r * a_r[k][63:32];
    assign pl_m[k] = focal_r * a_r[k][31:0];

    pjac_div u_div (
      .clk (clk),
      .en  (adv),
      .op  (dop_r[k]),
      .res (res_w[k])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 9; i++) begin
        tt_r[i] <= qp[i][63:29];
      end
      for (int i = 0; i < 3; i++) begin
        s1_pt_r[i] <= hpt_r[i];
        s1_sh_r[i] <= hsh_r[i];
        s2_pt_r[i] <= s1_pt_r[i];
        s2_sh_r[i] <= s1_sh_r[i];
        s3_sh_r[i] <= s2_sh_r[i];
        for (int j = 0; j < 3; j++) begin
          rm_r[i][j] <= sat32(rs[i][j]);
          rx_r[i][j] <= rxp[i][j][63:30];
        end
        s3_rs_r[i] <= tag_r[1].row ? rm_r[1][i] : rm_r[0][i];
        s3_r2_r[i] <= rm_r[2][i];
        p_r[i]     <= p_nxt[i];
        s4_rs_r[i] <= s3_rs_r[i];
        s4_r2_r[i] <= s3_r2_r[i];
        rz_r[i]    <= rz_m[i];
        cr_r[i]    <= cr_m[i];
      end
      zz_r  <= zz_m;
      sq_r  <= sq_m;
      axy_r <= axy_m;
      ax_r  <= ax_m;
      ay_r  <= ay_m;
      nx_r  <= p_r[0][31];
      ny_r  <= p_r[1][31];
      z_r   <= z_u;
      for (int k = 0; k < COLS; k++) begin
        a_r[k]      <= a_nxt[k];
        s6_neg_r[k] <= neg_nxt[k];
        s6_den_r[k] <= den_nxt[k];
        ph_r[k]     <= ph_m[k];
        pl_r[k]     <= pl_m[k];
        s7_neg_r[k] <= s6_neg_r[k];
        s7_den_r[k] <= s6_den_r[k];
        dop_r[k].n   <= (NW'(ph_r[k]) << 32) + NW'(pl_r[k]);
        dop_r[k].d   <= s7_den_r[k];
        dop_r[k].neg <= s7_neg_r[k];
      end
    end
  end

  assign out_valid     = tag_r[TAG_N-1].valid;
  assign out_row_is_v  = tag_r[TAG_N-1].row;
  assign out_last_row  = tag_r[TAG_N-1].row;
  assign out_depth_bad = tag_r[TAG_N-1].bad;
  assign out_dpt_x     = res_w[C_DPT_X];
  assign out_dpt_y     = res_w[C_DPT_Y];
  assign out_dpt_z     = res_w[C_DPT_Z];
  assign out_drot_x    = res_w[C_DROT_X];
  assign out_drot_y    = res_w[C_DROT_Y];
  assign out_drot_z    = res_w[C_DROT_Z];
  assign out_dmove_x   = res_w[C_DMOVE_X];
  assign out_dmove_y   = res_w[C_DMOVE_Y];
  assign out_dmove_z   = res_w[C_DMOVE_Z];

`ifndef ASSERT_OFF
  // the v row of a transaction directly follows its u row
  a_row_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_row_is_v |=>
      out_valid && out_row_is_v && $stable(out_depth_bad))
    else $error("v row did not follow u row");

  a_ready_adv: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!out_valid || out_ready))
    else $error("input accepted while pipeline stalled");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_depth_bad |->
      out_dpt_x == '0 && out_dpt_z == '0 && out_drot_y == '0 && out_dmove_z == '0)
    else $error("bad depth row not zeroed");

  a_move_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_row_is_v ? out_dmove_x == '0 : out_dmove_y == '0))
    else $error("structurally zero translation term is nonzero");
`endif

endmodule
